>>> src/acsa_pkg.sv
// Package for the ADC channel scan averager.
// Holds the fixed field widths, the bandgap mux code and the sequencer status type.
// Depends on nothing; imported by acsa_sequencer and adc_channel_scan_averager_unit.
package acsa_pkg;

    localparam int CHAN_BITS = 4;
    localparam int MUX_BITS = 4;
    localparam int AVG_BITS = 10;

    localparam logic [MUX_BITS-1:0] BANDGAP_MUX = 4'hE;

    typedef struct packed {
        logic                 settle;
        logic                 done;
        logic [CHAN_BITS-1:0] channel;
        logic [CHAN_BITS-1:0] channel_next;
    } seq_t;

endpackage

>>> src/acsa_sequencer.sv
// Channel and sample sequencer of the ADC channel scan averager.
// Tracks the scanned channel and the position in its settle-and-sum sequence.
// Depends on acsa_pkg.
module acsa_sequencer #(
    parameter int NUM_CHANNELS = 9,
    parameter int SAMPLES_AVERAGED = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    output acsa_pkg::seq_t seq
);
    import acsa_pkg::*;

    localparam int CNT_BITS = $clog2(SAMPLES_AVERAGED + 1);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SAMPLES_AVERAGED);
    localparam logic [CHAN_BITS-1:0] CHAN_LAST = CHAN_BITS'(NUM_CHANNELS - 1);

    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic [CHAN_BITS-1:0] channel_reg;
    logic [CHAN_BITS-1:0] channel_next;

    always_comb
    begin
        seq.settle = (count_reg == '0);
        seq.done = (count_reg == CNT_LAST);
        seq.channel = channel_reg;
        count_next = count_reg;
        channel_next = channel_reg;
        if (advance)
        begin
            if (seq.done)
            begin
                count_next = '0;
                channel_next = (channel_reg == CHAN_LAST) ? '0 : channel_reg + 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        seq.channel_next = channel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            channel_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            channel_reg <= channel_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LAST)
        else $error("sample count beyond its last position");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_reg <= CHAN_LAST)
        else $error("channel index out of range");

    a_wrap_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && seq.done) |=> (count_reg == '0))
        else $error("sequence did not restart after a finished average");

endmodule

>>> src/adc_channel_scan_averager_unit.sv
// Top level of the ADC channel scan averager: sequencer, accumulator and result register.
// Every accepted sample yields one result; a result carries an average when a channel completes.
// Depends on acsa_pkg and acsa_sequencer.
//
// The block scans NUM_CHANNELS converter channels in turn; the last one is the bandgap reference
// on mux code 14, the others use their own index. After each channel switch the first sample is
// dropped and the next SAMPLES_AVERAGED samples are summed, then the truncated average is
// reported and the scan moves on. The accumulate, the constant reciprocal multiply for the
// average and the channel step sit between the state registers and one output register, so a
// new sample is accepted every cycle while the output is not stalled. The result of a sample
// appears on the output in the cycle after it is accepted, together with the mux code to use
// for the next conversion.
module adc_channel_scan_averager_unit #(
    parameter int NUM_CHANNELS = 9,
    parameter int SAMPLES_AVERAGED = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [SAMPLE_BITS-1:0]         sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [acsa_pkg::MUX_BITS-1:0]  mux_code,
    output logic                           result_valid,
    output logic [acsa_pkg::CHAN_BITS-1:0] result_channel,
    output logic [acsa_pkg::AVG_BITS-1:0]  result_average
);
    import acsa_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(SAMPLES_AVERAGED);
    localparam int RECIP_SHIFT = SUM_BITS + $clog2(SAMPLES_AVERAGED);
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_AVERAGED) - 64'd1) / 64'(SAMPLES_AVERAGED);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
    localparam logic [CHAN_BITS-1:0] CHAN_LAST = CHAN_BITS'(NUM_CHANNELS - 1);

    logic                 accept;
    seq_t                 seq;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [SUM_BITS-1:0]  sum_next;
    logic [SUM_BITS-1:0]  sum_plus;
    logic [PROD_BITS-1:0] product;
    logic [PROD_BITS-1:0] quotient;
    logic [MUX_BITS-1:0]  mux_next;

    logic                 out_valid_reg;
    logic [MUX_BITS-1:0]  mux_code_reg;
    logic                 result_valid_reg;
    logic [CHAN_BITS-1:0] result_channel_reg;
    logic [AVG_BITS-1:0]  result_average_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;

    acsa_sequencer #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
    ) u_sequencer (
        .clk(clk),
        .rst_n(rst_n),
        .advance(accept),
        .seq(seq)
    );

    always_comb
    begin
        sum_plus = sum_reg + SUM_BITS'(sample);
        product = PROD_BITS'(sum_plus) * PROD_BITS'(RECIP);
        quotient = product >> RECIP_SHIFT;
        mux_next = (seq.channel_next == CHAN_LAST) ? BANDGAP_MUX : MUX_BITS'(seq.channel_next);
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = seq.settle ? '0 : sum_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mux_code_reg <= mux_next;
            result_valid_reg <= seq.done;
            result_channel_reg <= seq.done ? seq.channel : '0;
            result_average_reg <= seq.done ? quotient[AVG_BITS-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign mux_code = mux_code_reg;
    assign result_valid = result_valid_reg;
    assign result_channel = result_channel_reg;
    assign result_average = result_average_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty output register");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_valid_reg) |->
            (result_channel_reg == '0 && result_average_reg == '0))
        else $error("result fields not cleared on a request without an average");

    a_done_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && seq.done) |=> (out_valid_reg && result_valid_reg))
        else $error("finished average not reported");

    a_settle_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && seq.settle) |=> (sum_reg == '0))
        else $error("running sum not cleared on the settling sample");

endmodule
